// ===== src/bps_pkg.sv =====
// Shared types, constants and helpers for the byte pattern search block.
`default_nettype none

package bps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int BLOCK_MAX_DEF   = 65536;

    localparam int PAT_WORD_W = 64;
    localparam int PAT_LEN_W  = 5;
    localparam int OFFSET_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SEEN_LIMIT = 131071;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2,
        CFG_CASE_FOLD    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_block;
    } in_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } out_t;

    // Controls broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic advance;
        logic clear;
        logic fold;
    } cell_ctrl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/byte_pattern_search.sv =====
// A result is registered, with out_valid, at the edge that transfers the byte
// causing it. Throughput: one byte per cycle while the output is not stalled, set
// by the window of cells that compare their bytes with the pattern in the same cycle.
// A waiting result does not block the next byte unless the output is stalled.
// Reset clears the configuration, the byte window, the byte count and
// the output valid; no clearing pass is needed.
`default_nettype none

module byte_pattern_search #(
    parameter int PATTERN_MAX = bps_pkg::PATTERN_MAX_DEF,
    parameter int BLOCK_MAX   = bps_pkg::BLOCK_MAX_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bps_pkg::PAT_WORD_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire bps_pkg::in_t                        in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output bps_pkg::out_t                            out_data
);
    import bps_pkg::*;

    localparam int SEEN_CAP  = (BLOCK_MAX < SEEN_LIMIT) ? BLOCK_MAX : SEEN_LIMIT;
    localparam int SEEN_W    = $clog2(SEEN_CAP + 1);
    localparam int PAT_BYTES = 2 * PAT_WORD_W / 8;
    localparam int PIDX_W    = $clog2(PAT_BYTES);

    logic [PAT_WORD_W-1:0] pat_low_reg;
    logic [PAT_WORD_W-1:0] pat_high_reg;
    logic [PAT_LEN_W-1:0]  pat_len_reg;
    logic                  case_fold_reg;

    logic [SEEN_W-1:0]     seen_reg;
    logic [SEEN_W-1:0]     seen_next;
    logic                  reported_reg;
    logic                  reported_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_t                  out_data_reg;
    out_t                  out_data_next;

    logic                  in_accept;
    logic                  load_out;
    logic                  match;
    logic [PAT_LEN_W-1:0]  len_eff;
    logic [2*PAT_WORD_W-1:0] pat_all;
    logic [PATTERN_MAX-1:0] hit_vec;
    logic [PATTERN_MAX:0][7:0] byte_vec;
    logic [SEEN_W-1:0]     seen_inc;
    logic [SEEN_W-1:0]     offset_full;
    logic [31:0]           offset_wide;
    logic [OFFSET_W-1:0]   offset_sat;
    cell_ctrl_t            ctrl;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign ctrl.advance = in_accept && !reported_reg;
    assign ctrl.clear   = in_accept && in_data.end_of_block;
    assign ctrl.fold    = case_fold_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            pat_len_reg   <= '0;
            case_fold_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PATTERN_LOW:  pat_low_reg   <= cfg_data;
                CFG_PATTERN_HIGH: pat_high_reg  <= cfg_data;
                CFG_PATTERN_LEN:  pat_len_reg   <= cfg_data[PAT_LEN_W-1:0];
                CFG_CASE_FOLD:    case_fold_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign len_eff = (pat_len_reg > PAT_LEN_W'(PATTERN_MAX))
                   ? PAT_LEN_W'(PATTERN_MAX) : pat_len_reg;

    assign pat_all = {pat_high_reg, pat_low_reg};

    // Window of byte cells; cell PATTERN_MAX-1 takes the newest byte and each
    // cell hands its byte to the next older one. The last len_eff cells are
    // lined up with the pattern using the current registers.
    assign byte_vec[PATTERN_MAX] = in_data.data_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [PAT_LEN_W-1:0] pdiff;
        logic [PIDX_W-1:0]    pidx;
        logic                 active;

        assign active = (len_eff >= PAT_LEN_W'(PATTERN_MAX - k));
        assign pdiff  = len_eff - PAT_LEN_W'(PATTERN_MAX - k);
        assign pidx   = pdiff[PIDX_W-1:0];

        bps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .data_in  (byte_vec[k+1]),
            .pat_byte (pat_all[{pidx, 3'b000} +: 8]),
            .active   (active),
            .hit      (hit_vec[k]),
            .data_out (byte_vec[k])
        );
    end

    assign seen_inc = (seen_reg < SEEN_W'(SEEN_CAP)) ? (seen_reg + 1'b1) : seen_reg;

    assign match = (len_eff == '0)
                || ((seen_inc >= SEEN_W'(len_eff)) && (&hit_vec));

    // A match needs at least the pattern's length of bytes in the block, so
    // this difference never wraps on a match.
    assign offset_full = seen_inc - SEEN_W'(len_eff);
    assign offset_wide = 32'(offset_full);
    assign offset_sat  = (offset_wide > 32'(2**OFFSET_W - 1))
                       ? {OFFSET_W{1'b1}} : offset_wide[OFFSET_W-1:0];

    assign load_out = ctrl.advance && (match || in_data.end_of_block);

    always_comb
    begin
        seen_next      = seen_reg;
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (ctrl.advance)
        begin
            seen_next = seen_inc;
            if (match)
            begin
                reported_next = 1'b1;
            end
        end

        if (ctrl.clear)
        begin
            seen_next     = '0;
            reported_next = 1'b0;
        end

        if (load_out)
        begin
            out_valid_next             = 1'b1;
            out_data_next.found        = match;
            // An empty pattern always reports offset zero.
            out_data_next.match_offset = (match && (len_eff != '0)) ? offset_sat : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Once a block has reported, no further result may come from it.
    a_silent_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg |-> !load_out)
        else $error("result produced after the block already reported");

    // The end of a block leaves the count, the report mark and the window clear.
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.end_of_block)
            |=> (seen_reg == '0) && !reported_reg && (byte_vec[PATTERN_MAX-1:0] == '0))
        else $error("block state not cleared after end of block");

    // A new result never overwrites one that is still waiting to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

    // An empty pattern always matches at the first byte of the block.
    a_empty_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (len_eff == '0))
            |=> out_valid_reg && out_data_reg.found && (out_data_reg.match_offset == '0))
        else $error("empty pattern did not match at offset zero");

endmodule

`default_nettype wire

// ===== src/bps_cell.sv =====
// One cell of the byte window: holds one byte and compares the byte moving into it.
`default_nettype none

module bps_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bps_pkg::cell_ctrl_t     ctrl,
    input  wire logic [7:0]              data_in,
    input  wire logic [7:0]              pat_byte,
    input  wire logic                    active,
    output logic                         hit,
    output logic [7:0]                   data_out
);
    import bps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // The compare looks at the byte this cell will hold after the shift, so the
    // window seen by the pattern already includes the byte being transferred.
    // A cell outside the pattern's length always agrees.
    assign hit = !active
        || (fold_byte(data_in, ctrl.fold) == fold_byte(pat_byte, ctrl.fold));

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.advance)
        begin
            byte_next = data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign data_out = byte_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for byte_pattern_search, with its own prediction of each result.
module tb;

    import bps_pkg::*;

    localparam int SEEN_CAP     = (BLOCK_MAX_DEF < SEEN_LIMIT) ? BLOCK_MAX_DEF : SEEN_LIMIT;
    localparam int OFFSET_CAP   = (1 << OFFSET_W) - 1;
    localparam int RANDOM_ITEMS = 1720;
    localparam int LONG_BLOCK   = 200;
    localparam int MAX_WAIT     = 6;
    localparam int SETTLE       = 4;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [PAT_WORD_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_t                  out_data;

    // Copy of the configuration as the block should hold it.
    logic [PAT_WORD_W-1:0] pat_lo  = '0;
    logic [PAT_WORD_W-1:0] pat_hi  = '0;
    logic [PAT_LEN_W-1:0]  pat_len = '0;
    logic                  fold_on = 1'b0;

    // Copy of the per-block search state.
    logic [7:0] window [PATTERN_MAX_DEF];
    int         seen_count;
    logic       block_reported;

    out_t pending_reports [$];
    int   error_count    = 0;
    int   out_hold_left  = 0;
    bit   sender_idles   = 1'b1;
    bit   receiver_idles = 1'b1;

    byte_pattern_search DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always #1 clk = ~clk;

    function automatic void clear_block();
        int i;
        for (i = 0; i < PATTERN_MAX_DEF; i++)
        begin
            window[i] = '0;
        end
        seen_count     = 0;
        block_reported = 1'b0;
    endfunction

    function automatic logic [7:0] lower_letter(input logic [7:0] c);
        if (fold_on && c >= "A" && c <= "Z")
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pattern_byte(input int i);
        if (i < 8)
        begin
            return pat_lo[i*8 +: 8];
        end
        return pat_hi[(i-8)*8 +: 8];
    endfunction

    function automatic int active_length();
        return (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
    endfunction

    // Moves the search state on by one byte and queues the report it causes, if any.
    function automatic void advance_search(input logic [7:0] b, input logic eob);
        int   i;
        int   len;
        int   offs;
        logic hit;
        out_t rpt;
        if (block_reported)
        begin
            if (eob)
            begin
                clear_block();
            end
            return;
        end
        len = active_length();
        for (i = 0; i < PATTERN_MAX_DEF - 1; i++)
        begin
            window[i] = window[i+1];
        end
        window[PATTERN_MAX_DEF-1] = b;
        if (seen_count < SEEN_CAP)
        begin
            seen_count++;
        end
        hit  = 1'b0;
        offs = 0;
        if (len == 0)
        begin
            hit = 1'b1;
        end
        else if (seen_count >= len)
        begin
            hit = 1'b1;
            for (i = 0; i < len; i++)
            begin
                if (lower_letter(window[PATTERN_MAX_DEF-len+i]) != lower_letter(pattern_byte(i)))
                begin
                    hit = 1'b0;
                end
            end
            offs = seen_count - len;
            if (offs > OFFSET_CAP)
            begin
                offs = OFFSET_CAP;
            end
        end
        if (hit || eob)
        begin
            rpt.found        = hit;
            rpt.match_offset = hit ? offs[OFFSET_W-1:0] : '0;
            pending_reports.push_back(rpt);
            if (eob)
            begin
                clear_block();
            end
            else
            begin
                block_reported = 1'b1;
            end
        end
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [PAT_WORD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_LOW:  pat_lo  = val;
            CFG_PATTERN_HIGH: pat_hi  = val;
            CFG_PATTERN_LEN:  pat_len = val[PAT_LEN_W-1:0];
            CFG_CASE_FOLD:    fold_on = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = sender_idles ? int'($urandom_range(0, MAX_WAIT)) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, end_of_block: eob};
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_search(b, eob);
    endtask

    // Holds off the sender until every queued report has come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result: found=%0d match_offset=%0d",
                       out_data.found, out_data.match_offset);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (out_data.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, out_data.found);
                    error_count++;
                end
                if (out_data.match_offset !== want.match_offset)
                begin
                    $error("match_offset: expected %0d, got %0d",
                           want.match_offset, out_data.match_offset);
                    error_count++;
                end
            end
            out_hold_left = receiver_idles ? int'($urandom_range(0, MAX_WAIT)) : 0;
        end
        else if (out_hold_left != 0)
        begin
            out_hold_left--;
        end
        out_stall <= (out_hold_left != 0);
    end

    // Reset pattern: a zero-length pattern matches on the first byte of each block.
    task automatic test_empty_pattern();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b1);
        wait_idle();
    endtask

    // A length above the maximum acts as a full 16-byte pattern.
    task automatic test_short_and_full_pattern();
        int i;
        write_reg(CFG_PATTERN_LOW,  64'hFF00_FF00_4142_7A5A);
        write_reg(CFG_PATTERN_HIGH, 64'h0080_7F01_FEFF_0020);
        write_reg(CFG_PATTERN_LEN,  64'd31);
        write_reg(CFG_CASE_FOLD,    64'd0);
        // A block shorter than the pattern ends without a match.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // The match completes on the last byte of the block.
        for (i = 0; i < PATTERN_MAX_DEF; i++)
        begin
            send_byte(pattern_byte(i), i == PATTERN_MAX_DEF - 1);
        end
        wait_idle();
    endtask

    task automatic test_case_fold_and_ignore();
        write_reg(CFG_PATTERN_LOW,  {48'h0, "b", "A"});
        write_reg(CFG_PATTERN_HIGH, 64'd0);
        write_reg(CFG_PATTERN_LEN,  64'd2);
        write_reg(CFG_CASE_FOLD,    64'd1);
        send_byte("a", 1'b0);
        send_byte("B", 1'b0);
        // Bytes after a match are dropped until the block ends.
        send_byte("x", 1'b0);
        send_byte("y", 1'b1);
        wait_idle();
    endtask

    // The compare uses the new registers against bytes taken in before the write.
    task automatic test_midblock_write();
        send_byte("q", 1'b0);
        wait_idle();
        write_reg(CFG_PATTERN_LOW, {48'h0, "z", "q"});
        write_reg(CFG_CASE_FOLD,   64'd0);
        send_byte("z", 1'b1);
        wait_idle();
    endtask

    // A match late in a long block, sent back to back with no stalls.
    task automatic test_long_block();
        int i;
        write_reg(CFG_PATTERN_LOW, {32'h0, "z", "y", "x", "w"});
        write_reg(CFG_PATTERN_LEN, 64'd4);
        write_reg(CFG_CASE_FOLD,   64'd0);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (i = 0; i < LONG_BLOCK - 4; i++)
        begin
            send_byte(8'h00, 1'b0);
        end
        for (i = 0; i < 4; i++)
        begin
            send_byte(pattern_byte(i), i == 3);
        end
        wait_idle();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_random_blocks();
        int             sent;
        int             i;
        int             k;
        int             blocks;
        int             blk_len;
        int             start;
        int             len;
        bit             plant;
        logic [7:0]     b;
        logic [127:0]   words;
        logic [63:0]    raw;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            for (i = 0; i < PATTERN_MAX_DEF; i++)
            begin
                case ($urandom_range(0, 2))
                    0:       words[i*8 +: 8] = 8'("a" + $urandom_range(0, 3));
                    1:       words[i*8 +: 8] = 8'("A" + $urandom_range(0, 25));
                    default: words[i*8 +: 8] = 8'($urandom_range(0, 255));
                endcase
            end
            case ($urandom_range(0, 19))
                0:       words = '1;
                1:       words = '0;
                default: ;
            endcase
            write_reg(CFG_PATTERN_LOW,  words[63:0]);
            write_reg(CFG_PATTERN_HIGH, words[127:64]);
            raw = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0:       raw[PAT_LEN_W-1:0] = 5'd0;
                1:       raw[PAT_LEN_W-1:0] = 5'd16;
                2:       raw[PAT_LEN_W-1:0] = 5'($urandom_range(17, 31));
                3:       raw[PAT_LEN_W-1:0] = 5'($urandom_range(7, 15));
                default: raw[PAT_LEN_W-1:0] = 5'($urandom_range(1, 6));
            endcase
            write_reg(CFG_PATTERN_LEN, raw);
            raw = {$urandom, $urandom};
            write_reg(CFG_CASE_FOLD, raw);
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            len    = active_length();
            blocks = $urandom_range(3, 10);
            repeat (blocks)
            begin
                blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 20);
                plant = ($urandom_range(0, 3) != 0);
                start = plant ? $urandom_range(0, blk_len - 1) : blk_len;
                for (k = 0; k < blk_len; k++)
                begin
                    if (plant && k >= start && k - start < len)
                    begin
                        b = pattern_byte(k - start);
                        if (fold_on && ((b | 8'h20) >= "a") && ((b | 8'h20) <= "z")
                            && $urandom_range(0, 1))
                        begin
                            b = b ^ 8'h20;
                        end
                        if ($urandom_range(0, 19) == 0)
                        begin
                            b = 8'($urandom_range(0, 255));
                        end
                    end
                    else
                    begin
                        case ($urandom_range(0, 3))
                            0, 1:
                            begin
                                b = (len > 0) ? pattern_byte($urandom_range(0, len - 1))
                                              : 8'($urandom_range(0, 255));
                            end
                            2:       b = 8'(($urandom_range(0, 1) ? "a" : "A")
                                            + $urandom_range(0, 25));
                            default: b = 8'($urandom_range(0, 255));
                        endcase
                    end
                    send_byte(b, k == blk_len - 1);
                    sent++;
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        clear_block();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pattern();
        test_short_and_full_pattern();
        test_case_fold_and_ignore();
        test_midblock_write();
        test_long_block();
        test_random_blocks();
        wait_idle();
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
